// ===== hdl/ttl_pkg.sv =====
// Shared types, codes and helpers for the TTL duration parser.
package ttl_pkg;

    localparam int unsigned SECS_W = 31;
    localparam int unsigned SCALE_W = 20;

    localparam logic [SECS_W-1:0] TTL_MAX = 31'h7FFF_FFFF;

    // Parse phases
    localparam logic [1:0] PH_INITIAL = 2'd0;
    localparam logic [1:0] PH_NUMBER  = 2'd1;
    localparam logic [1:0] PH_UNIT    = 2'd2;

    // Result / held status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_SYNTAX = 2'd1;
    localparam logic [1:0] ST_STOP   = 2'd2;

    // Unit codes, ordered from smallest to largest
    localparam logic [2:0] UNIT_NONE = 3'd0;
    localparam logic [2:0] UNIT_S    = 3'd1;
    localparam logic [2:0] UNIT_M    = 3'd2;
    localparam logic [2:0] UNIT_H    = 3'd3;
    localparam logic [2:0] UNIT_D    = 3'd4;
    localparam logic [2:0] UNIT_W    = 3'd5;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    // Parser state carried from byte to byte
    typedef struct packed {
        logic [1:0]        phase;
        logic [1:0]        status;
        logic [SECS_W-1:0] number;
        logic [SECS_W-1:0] total;
        logic [2:0]        unit;
    } parse_state_t;

    localparam parse_state_t STATE_RESET = '{
        phase:  PH_INITIAL,
        status: ST_OK,
        number: '0,
        total:  '0,
        unit:   UNIT_NONE
    };

    // Unit letter to code, either case; zero when not a unit letter
    function automatic logic [2:0] unit_code_of(input logic [7:0] ch);
        logic [7:0] lower;
        lower = ch | 8'h20;
        unique case (lower)
            8'h73:   return UNIT_S;
            8'h6D:   return UNIT_M;
            8'h68:   return UNIT_H;
            8'h64:   return UNIT_D;
            8'h77:   return UNIT_W;
            default: return UNIT_NONE;
        endcase
    endfunction

    // Seconds per unit
    function automatic logic [SCALE_W-1:0] unit_scale(input logic [2:0] code);
        unique case (code)
            UNIT_S:  return 20'd1;
            UNIT_M:  return 20'd60;
            UNIT_H:  return 20'd3600;
            UNIT_D:  return 20'd86400;
            UNIT_W:  return 20'd604800;
            default: return 20'd0;
        endcase
    endfunction

    // Saturating add of two values that are each at most TTL_MAX
    function automatic logic [SECS_W-1:0] sat_add(input logic [SECS_W-1:0] a,
                                                  input logic [SECS_W-1:0] b);
        logic [SECS_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum > {1'b0, TTL_MAX})
            return TTL_MAX;
        return sum[SECS_W-1:0];
    endfunction

endpackage

// ===== hdl/ttl_step.sv =====
// Next-state logic of the TTL parser for one input byte.
module ttl_step (
    input  ttl_pkg::parse_state_t state,
    input  logic [7:0]            ttl_char,
    output ttl_pkg::parse_state_t state_next
);

    logic                                    is_digit;
    logic [3:0]                              digit_val;
    logic [ttl_pkg::SECS_W-1:0]              digit_ext;
    logic [2:0]                              code;
    logic [ttl_pkg::SECS_W+3:0]              times_ten;
    logic [ttl_pkg::SECS_W-1:0]              times_ten_sat;
    logic [ttl_pkg::SECS_W-1:0]              accum;
    logic [ttl_pkg::SECS_W+ttl_pkg::SCALE_W-1:0] scaled;
    logic [ttl_pkg::SECS_W-1:0]              scaled_sat;

    // Character classification
    assign is_digit  = (ttl_char >= ttl_pkg::CHAR_ZERO) && (ttl_char <= ttl_pkg::CHAR_NINE);
    assign digit_val = ttl_char[3:0];
    assign digit_ext = {{(ttl_pkg::SECS_W-4){1'b0}}, digit_val};
    assign code      = ttl_pkg::unit_code_of(ttl_char);

    // number * 10 + digit, saturating
    assign times_ten = ({4'b0, state.number} << 3) + ({4'b0, state.number} << 1);
    assign times_ten_sat = (times_ten > {4'b0, ttl_pkg::TTL_MAX}) ?
                           ttl_pkg::TTL_MAX : times_ten[ttl_pkg::SECS_W-1:0];
    assign accum = ttl_pkg::sat_add(times_ten_sat, digit_ext);

    // number * unit scale, saturating
    assign scaled = {{ttl_pkg::SCALE_W{1'b0}}, state.number} *
                    {{ttl_pkg::SECS_W{1'b0}}, ttl_pkg::unit_scale(code)};
    assign scaled_sat = (scaled > {{ttl_pkg::SCALE_W{1'b0}}, ttl_pkg::TTL_MAX}) ?
                        ttl_pkg::TTL_MAX : scaled[ttl_pkg::SECS_W-1:0];

    // Phase transitions; bytes after an error or stop leave the state alone
    always_comb
    begin
        state_next = state;
        if (state.status == ttl_pkg::ST_OK)
        begin
            unique case (state.phase)
                ttl_pkg::PH_INITIAL:
                begin
                    if (!is_digit)
                        state_next.status = ttl_pkg::ST_SYNTAX;
                    else
                    begin
                        state_next.number = digit_ext;
                        state_next.phase  = ttl_pkg::PH_NUMBER;
                    end
                end
                ttl_pkg::PH_NUMBER:
                begin
                    if (is_digit)
                        state_next.number = accum;
                    else if (code != ttl_pkg::UNIT_NONE)
                    begin
                        // units must strictly fall; any unit allowed first
                        if (state.unit != ttl_pkg::UNIT_NONE && code >= state.unit)
                            state_next.status = ttl_pkg::ST_SYNTAX;
                        else
                        begin
                            state_next.unit   = code;
                            state_next.number = scaled_sat;
                            state_next.phase  = ttl_pkg::PH_UNIT;
                        end
                    end
                    else
                        state_next.status = ttl_pkg::ST_STOP;
                end
                default:
                begin
                    // after a unit: only a digit, and never after seconds
                    if (!is_digit || state.unit == ttl_pkg::UNIT_S)
                        state_next.status = ttl_pkg::ST_SYNTAX;
                    else
                    begin
                        state_next.total  = ttl_pkg::sat_add(state.total, state.number);
                        state_next.number = digit_ext;
                        state_next.phase  = ttl_pkg::PH_NUMBER;
                    end
                end
            endcase
        end
    end

endmodule

// ===== hdl/ttl_duration_parser.sv =====
// Top level of the TTL duration parser: input register, parse stage, result register.
// Throughput: one byte per cycle while out_ready does not hold the output back, with no gaps between texts.
// Result path: after its last byte is accepted, a text's result passes from the input register
// through the parse stage with the state update to the output register, which holds
// the final saturating sum.
// Reset: rst_n clears all valid flags and the parser state; no item is in flight after it.
module ttl_duration_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  ttl_char,
    input  logic        last_char,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  parse_status,
    output logic [30:0] ttl_seconds
);

    // Stage registers
    logic                       s1_valid_reg;
    logic [7:0]                 s1_char_reg;
    logic                       s1_last_reg;
    logic                       s2_valid_reg;
    logic [1:0]                 s2_status_reg;
    logic [ttl_pkg::SECS_W-1:0] s2_number_reg;
    logic [ttl_pkg::SECS_W-1:0] s2_total_reg;
    logic                       out_valid_reg;
    logic [1:0]                 out_status_reg;
    logic [ttl_pkg::SECS_W-1:0] out_secs_reg;

    ttl_pkg::parse_state_t      state_reg;
    ttl_pkg::parse_state_t      state_next;

    logic                       en1;
    logic                       en2;
    logic                       en3;
    logic                       s1_fire;
    logic [ttl_pkg::SECS_W-1:0] secs_next;

    // Stage enables: a stage loads when empty or when its content moves on
    assign en3     = !out_valid_reg || out_ready;
    assign en2     = !s2_valid_reg || en3;
    assign en1     = !s1_valid_reg || en2;
    assign s1_fire = s1_valid_reg && en2;
    assign in_ready = en1;

    ttl_step u_step (
        .state      (state_reg),
        .ttl_char   (s1_char_reg),
        .state_next (state_next)
    );

    // Final sum for the result register
    assign secs_next = (s2_status_reg == ttl_pkg::ST_OK) ?
                       ttl_pkg::sat_add(s2_total_reg, s2_number_reg) : '0;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= ttl_pkg::STATE_RESET;
        end
        else
        begin
            if (en1)
                s1_valid_reg <= in_valid;
            if (en2)
                s2_valid_reg <= s1_fire && s1_last_reg;
            if (en3)
                out_valid_reg <= s2_valid_reg;
            if (s1_fire)
            begin
                if (s1_last_reg)
                    state_reg <= ttl_pkg::STATE_RESET;
                else
                    state_reg <= state_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && en1)
        begin
            s1_char_reg <= ttl_char;
            s1_last_reg <= last_char;
        end
        if (s1_fire && s1_last_reg)
        begin
            s2_status_reg <= state_next.status;
            s2_number_reg <= state_next.number;
            s2_total_reg  <= state_next.total;
        end
        if (en3 && s2_valid_reg)
        begin
            out_status_reg <= s2_status_reg;
            out_secs_reg   <= secs_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign parse_status = out_status_reg;
    assign ttl_seconds  = out_secs_reg;

    // Assertions
    a_err_zero_secs: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_status_reg != ttl_pkg::ST_OK) |-> out_secs_reg == '0)
        else $error("nonzero seconds on an error result");

    a_state_clears: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && s1_last_reg |=>
            state_reg.phase == ttl_pkg::PH_INITIAL && state_reg.status == ttl_pkg::ST_OK
            && state_reg.unit == ttl_pkg::UNIT_NONE)
        else $error("parser state not cleared after last byte");

    a_error_held: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.status != ttl_pkg::ST_OK) && s1_fire && !s1_last_reg |=>
            $stable(state_reg))
        else $error("state changed after error or stop");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> in_ready)
        else $error("input not ready with empty input register");

endmodule
